### design/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-screen plotter package
// Shared widths, constants and payload types of the viewport transform.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Screen mapping constants.
	localparam int SCREEN_SPAN = 128;
	localparam int ROW_OFFSET  = 32;

	// Field widths.
	localparam int COORD_W   = 16;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Magnitude of a coordinate and of its scaled value (|v| * 7 / 6 < 2^16).
	localparam int MAG_W    = 16;
	localparam int SCALED_W = MAG_W + 1;
	localparam int DIFF_W   = SCALED_W + 1;

	// A window span is at most 65535, and the clipped numerator never exceeds it.
	localparam int SPAN_W = 16;

	// The quotient num * SCREEN_SPAN / span lies in 0 .. SCREEN_SPAN.
	localparam int QUO_W = $clog2(SCREEN_SPAN + 1);
	localparam int REM_W = SPAN_W + QUO_W;

	// Scaling by 7/6 is a multiplication by a rounded-up reciprocal of 6.
	// With a shift of 21 the floor is exact for every product below 2^19.
	localparam int SCALE_NUM   = 7;
	localparam int SCALE_DEN   = 6;
	localparam int RECIP_SHIFT = 21;
	localparam longint SCALE_RECIP =
		((longint'(1) << RECIP_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
	localparam int SCALE_MUL_W = 22;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(SCALE_NUM * SCALE_RECIP);
	localparam int MULT_W = MAG_W + SCALE_MUL_W;

	localparam logic [PIX_W-1:0] ROW_BASE = PIX_W'(ROW_OFFSET);

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_col;
		logic [PIX_W-1:0] pixel_row;
		logic             block_last;
	} pixel_t;

	// Division request for both axes: num / span, scaled by SCREEN_SPAN.
	typedef struct packed {
		logic [SPAN_W-1:0] num_x;
		logic [SPAN_W-1:0] span_x;
		logic [SPAN_W-1:0] num_y;
		logic [SPAN_W-1:0] span_y;
	} div_req_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo_x;
		logic [QUO_W-1:0] quo_y;
	} div_res_t;

endpackage

### design/pts_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined screen divider
// Computes num * SCREEN_SPAN / span for both axes, one quotient bit per restoring stage.
// ----------------------------------------------------------------------------
module pts_div_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pts_pkg::div_req_t in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output pts_pkg::div_res_t out_res
);
	import pts_pkg::*;

	localparam int NST  = QUO_W + 1;
	localparam int LAST = NST - 1;

	logic [NST-1:0]    vld_s;
	logic [NST:0]      take;
	logic [REM_W-1:0]  rem_s [NST][2];
	logic [SPAN_W-1:0] den_s [NST][2];
	logic [QUO_W-1:0]  quo_s [NST][2];
	logic [SPAN_W-1:0] num_in [2];
	logic [SPAN_W-1:0] den_in [2];

	assign num_in[0] = in_req.num_x;
	assign num_in[1] = in_req.num_y;
	assign den_in[0] = in_req.span_x;
	assign den_in[1] = in_req.span_y;

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		take[NST] = out_ready;
		for (int i = NST - 1; i >= 0; i--) begin
			take[i] = !vld_s[i] || take[i+1];
		end
	end

	assign in_ready = take[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (take[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (take[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// First stage scales the numerator.
	always_ff @(posedge clk) begin
		if (take[0]) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= REM_W'(num_in[l]) * REM_W'(SCREEN_SPAN);
				den_s[0][l] <= den_in[l];
				quo_s[0][l] <= '0;
			end
		end
	end

	// Restoring steps, most significant quotient bit first. A zero span never
	// sets a bit, so its quotient stays zero.
	for (genvar i = 1; i < NST; i++) begin : g_step
		localparam int QB = QUO_W - i;
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [REM_W-1:0] dsh;
			logic [REM_W:0]   trial;
			logic             hit;

			assign dsh   = REM_W'(den_s[i-1][l]) << QB;
			assign trial = {1'b0, rem_s[i-1][l]} - {1'b0, dsh};
			assign hit   = (den_s[i-1][l] != '0) && !trial[REM_W];

			always_ff @(posedge clk) begin
				if (take[i]) begin
					rem_s[i][l] <= hit ? trial[REM_W-1:0] : rem_s[i-1][l];
					den_s[i][l] <= den_s[i-1][l];
					quo_s[i][l] <= quo_s[i-1][l] | (QUO_W'(hit) << QB);
				end
			end
		end
	end

	assign out_valid     = vld_s[LAST];
	assign out_res.quo_x = quo_s[LAST][0];
	assign out_res.quo_y = quo_s[LAST][1];

`ifndef ASSERT_OFF
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.quo_x <= QUO_W'(SCREEN_SPAN))
			&& (out_res.quo_y <= QUO_W'(SCREEN_SPAN)))
		else $error("quotient beyond screen span");

	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((den_s[LAST][0] == '0) || (den_s[LAST][1] == '0))
			|-> ((den_s[LAST][0] != '0) || (quo_s[LAST][0] == '0))
			&& ((den_s[LAST][1] != '0) || (quo_s[LAST][1] == '0)))
		else $error("zero span gave a nonzero quotient");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((den_s[LAST][0] == '0) || (rem_s[LAST][0] < REM_W'(den_s[LAST][0])))
			&& ((den_s[LAST][1] == '0) || (rem_s[LAST][1] < REM_W'(den_s[LAST][1]))))
		else $error("final remainder not below the span");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res))
		else $error("stalled quotient changed");
`endif

endmodule

### design/point_to_screen_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-screen plotter
// Scales a world point by 7/6, clips it to a window and maps it to a 2x2
// pixel block on screen.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  point     in         point_valid / point_stall point_data (point_x, point_y)
//  pixel     out        pixel_valid / pixel_stall pixel_data (col, row, last)
//  config    in         cfg_we                    cfg_index, cfg_data
//
// A point request is accepted in any cycle in which the first stage is free,
// so points enter back to back until the pipeline fills. The first pixel is
// offered once its point has passed stages 1 to 4, the divider stages and
// the pixel serializer.
// Each point inside the window leaves as four pixel requests, one per cycle
// while pixel_stall is low; the serializer takes the next point as the last
// pixel leaves. A point outside the window drops out after the clip stage.
// Reset empties the pipeline and loads the window to +/-2500; no clearing pass.
// A stall on the pixel side backs up stage by stage; nothing is lost.
//
module point_to_screen_plotter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            point_valid,
	output logic                            point_stall,
	input  pts_pkg::point_t                 point_data,
	output logic                            pixel_valid,
	input  logic                            pixel_stall,
	output pts_pkg::pixel_t                 pixel_data,
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pts_pkg::COORD_W-1:0]     cfg_data
);
	import pts_pkg::*;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MAX = 2'd3;

	localparam logic signed [COORD_W-1:0] WIN_MIN_RST = -16'sd2500;
	localparam logic signed [COORD_W-1:0] WIN_MAX_RST = 16'sd2500;

	// Pixel position inside the 2x2 block.
	localparam logic [1:0] PIX_FIRST = 2'd0;
	localparam logic [1:0] PIX_LAST  = 2'd3;

	logic signed [COORD_W-1:0] win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;

	// Window registers. The user must write them only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_min_q <= WIN_MIN_RST;
			win_x_max_q <= WIN_MAX_RST;
			win_y_min_q <= WIN_MIN_RST;
			win_y_max_q <= WIN_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIN_X_MIN: win_x_min_q <= cfg_data;
				REG_WIN_X_MAX: win_x_max_q <= cfg_data;
				REG_WIN_Y_MIN: win_y_min_q <= cfg_data;
				REG_WIN_Y_MAX: win_y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its content
	// moves on in the same cycle.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic take_s1, take_s2, take_s3, take_s4;
	logic div_in_ready, div_out_valid, div_out_ready;

	assign take_s4     = !vld_s4 || div_in_ready;
	assign take_s3     = !vld_s3 || take_s4;
	assign take_s2     = !vld_s2 || take_s3;
	assign take_s1     = !vld_s1 || take_s2;
	assign point_stall = !take_s1;

	// Stage 1: sign and magnitude. The division truncates toward zero, so the
	// magnitude is scaled and the sign put back afterward.
	logic             neg_x_s1, neg_y_s1;
	logic [MAG_W-1:0] mag_x_s1, mag_y_s1;
	logic [MAG_W-1:0] mag_x, mag_y;

	assign mag_x = point_data.point_x[COORD_W-1] ?
		MAG_W'(-point_data.point_x) : MAG_W'(point_data.point_x);
	assign mag_y = point_data.point_y[COORD_W-1] ?
		MAG_W'(-point_data.point_y) : MAG_W'(point_data.point_y);

	always_ff @(posedge clk) begin
		if (take_s1) begin
			neg_x_s1 <= point_data.point_x[COORD_W-1];
			neg_y_s1 <= point_data.point_y[COORD_W-1];
			mag_x_s1 <= mag_x;
			mag_y_s1 <= mag_y;
		end
	end

	// Stage 2: |v| * 7 / 6 through the reciprocal multiplier.
	logic              neg_x_s2, neg_y_s2;
	logic [MAG_W-1:0]  scl_x_s2, scl_y_s2;
	logic [MULT_W-1:0] prod_x, prod_y;

	assign prod_x = MULT_W'(mag_x_s1) * MULT_W'(SCALE_MUL);
	assign prod_y = MULT_W'(mag_y_s1) * MULT_W'(SCALE_MUL);

	always_ff @(posedge clk) begin
		if (take_s2) begin
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			scl_x_s2 <= prod_x[RECIP_SHIFT +: MAG_W];
			scl_y_s2 <= prod_y[RECIP_SHIFT +: MAG_W];
		end
	end

	// Stage 3: restore the sign of the scaled point.
	logic signed [SCALED_W-1:0] pos_x_s3, pos_y_s3;
	logic signed [SCALED_W-1:0] unsg_x, unsg_y;

	assign unsg_x = {1'b0, scl_x_s2};
	assign unsg_y = {1'b0, scl_y_s2};

	always_ff @(posedge clk) begin
		if (take_s3) begin
			pos_x_s3 <= neg_x_s2 ? -unsg_x : unsg_x;
			pos_y_s3 <= neg_y_s2 ? -unsg_y : unsg_y;
		end
	end

	// Stage 4: clip. The four distances to the window edges are all
	// nonnegative exactly when the point is inside, bounds included. The
	// distance from the left edge and from the top edge are the numerators.
	logic signed [DIFF_W-1:0] x_ext, y_ext;
	logic signed [DIFF_W-1:0] xmin_ext, xmax_ext, ymin_ext, ymax_ext;
	logic signed [DIFF_W-1:0] dx_lo, dx_hi, dy_lo, dy_hi, spx, spy;
	logic                     in_win;
	div_req_t                 div_req_s4;
	div_res_t                 div_res;

	always_comb begin
		x_ext    = {{(DIFF_W-SCALED_W){pos_x_s3[SCALED_W-1]}}, pos_x_s3};
		y_ext    = {{(DIFF_W-SCALED_W){pos_y_s3[SCALED_W-1]}}, pos_y_s3};
		xmin_ext = {{(DIFF_W-COORD_W){win_x_min_q[COORD_W-1]}}, win_x_min_q};
		xmax_ext = {{(DIFF_W-COORD_W){win_x_max_q[COORD_W-1]}}, win_x_max_q};
		ymin_ext = {{(DIFF_W-COORD_W){win_y_min_q[COORD_W-1]}}, win_y_min_q};
		ymax_ext = {{(DIFF_W-COORD_W){win_y_max_q[COORD_W-1]}}, win_y_max_q};
		dx_lo    = x_ext - xmin_ext;
		dx_hi    = xmax_ext - x_ext;
		dy_lo    = y_ext - ymin_ext;
		dy_hi    = ymax_ext - y_ext;
		spx      = xmax_ext - xmin_ext;
		spy      = ymax_ext - ymin_ext;
		in_win   = !dx_lo[DIFF_W-1] && !dx_hi[DIFF_W-1]
			&& !dy_lo[DIFF_W-1] && !dy_hi[DIFF_W-1];
	end

	always_ff @(posedge clk) begin
		if (take_s4) begin
			div_req_s4.num_x  <= dx_lo[SPAN_W-1:0];
			div_req_s4.span_x <= spx[SPAN_W-1:0];
			div_req_s4.num_y  <= dy_hi[SPAN_W-1:0];
			div_req_s4.span_y <= spy[SPAN_W-1:0];
		end
	end

	// Valid bits of the front stages; a clipped point leaves no valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (take_s1) begin
				vld_s1 <= point_valid;
			end
			if (take_s2) begin
				vld_s2 <= vld_s1;
			end
			if (take_s3) begin
				vld_s3 <= vld_s2;
			end
			if (take_s4) begin
				vld_s4 <= vld_s3 && in_win;
			end
		end
	end

	// Stages 5 and on: the screen divider, one quotient bit per restoring stage.
	pts_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_ready  (div_in_ready),
		.in_req    (div_req_s4),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_res   (div_res)
	);

	// Pixel serializer: holds the block corner and steps through the four
	// pixels. It takes the next point as the last pixel leaves.
	logic             pixel_valid_q;
	logic [1:0]       pix_cnt_q;
	logic [PIX_W-1:0] base_col_q, base_row_q;
	logic             pix_fire;

	assign pix_fire      = pixel_valid_q && !pixel_stall;
	assign div_out_ready = !pixel_valid_q || (pix_fire && (pix_cnt_q == PIX_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
			pix_cnt_q     <= PIX_FIRST;
		end else if (div_out_ready) begin
			pixel_valid_q <= div_out_valid;
			pix_cnt_q     <= PIX_FIRST;
		end else if (pix_fire) begin
			pix_cnt_q <= pix_cnt_q + 2'd1;
		end
	end

	// Column and row wrap to eight bits.
	always_ff @(posedge clk) begin
		if (div_out_ready && div_out_valid) begin
			base_col_q <= PIX_W'(div_res.quo_x);
			base_row_q <= ROW_BASE + PIX_W'(div_res.quo_y);
		end
	end

	assign pixel_valid = pixel_valid_q;

	always_comb begin
		pixel_data.pixel_col  = base_col_q + PIX_W'(pix_cnt_q[0]);
		pixel_data.pixel_row  = base_row_q + PIX_W'(pix_cnt_q[1]);
		pixel_data.block_last = (pix_cnt_q == PIX_LAST);
	end

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> vld_s1)
		else $error("point stalled while the first stage is free");

	a_num_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (div_req_s4.num_x <= div_req_s4.span_x)
			&& (div_req_s4.num_y <= div_req_s4.span_y))
		else $error("clipped numerator exceeds the span");

	a_block_whole: assert property (@(posedge clk) disable iff (!arst_n)
		pix_fire && !pixel_data.block_last |=> pixel_valid)
		else $error("pixel block cut short");

	a_block_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix_fire && (pix_cnt_q == PIX_FIRST)
			|=> (pixel_data.pixel_col == $past(pixel_data.pixel_col) + PIX_W'(1))
			&& (pixel_data.pixel_row == $past(pixel_data.pixel_row)))
		else $error("second pixel not right of the first");
`endif

endmodule
